// ===== src/assert_macros.svh =====
// Assertion macros shared by the point morph RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WCPM_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define WCPM_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/wcpm_pkg.sv =====
// Package for the point morph core: constants, register indexes, table builders and types.
`timescale 1ns / 1ps
package wcpm_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int EXP_DEPTH = 1024;
	localparam int E_W = 10;
	localparam int STAGES = 17;
	localparam int W_W = 23;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 25;

	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd2;

	localparam longint unsigned SIN_COEF [5] = '{
		64'd1686629713, 64'd693598668, 64'd85569278, 64'd5026991, 64'd172276
	};

	localparam longint unsigned EXP_POW [10] = '{
		64'd4228380013, 64'd4162825023, 64'd4034748370, 64'd3790295324, 64'd3344923881,
		64'd2605029455, 64'd1580030170, 64'd581260584, 64'd78665074, 64'd1440779
	};

	typedef struct packed {
		logic ld_mul;
		logic ld_sum;
		logic ld_out;
	} blend_ctl_t;

	typedef struct packed {
		logic [11:0]        ax;
		logic [11:0]        bx;
		logic signed [15:0] c1x;
		logic signed [15:0] c2x;
		logic [11:0]        ay;
		logic [11:0]        by;
		logic signed [15:0] c1y;
		logic signed [15:0] c2y;
	} coord_t;

	// Shift right by n with rounding to nearest, halves away from zero.
	function automatic logic signed [63:0] rshift_rnd(input logic signed [63:0] v,
		input int unsigned n);
		logic [63:0] mag;
		logic [63:0] half;
		half = 64'd1 << (n - 1);
		mag = v[63] ? 64'(-v) : 64'(v);
		mag = (mag + half) >> n;
		return v[63] ? -$signed(mag) : $signed(mag);
	endfunction

	// Sine of a Q32 turn u, scaled by 0.45, Q16.
	function automatic logic signed [15:0] sine_q16(input longint unsigned u);
		longint unsigned quad;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned sv;
		longint unsigned mag;
		quad = (u >> 30) & 64'd3;
		r = u & 64'h3FFF_FFFF;
		x = quad[0] ? (64'd1 << 30) - r : r;
		x2 = (x * x) >> 30;
		t = SIN_COEF[4];
		for (int i = 3; i >= 0; i--) begin
			t = SIN_COEF[i] - ((x2 * t) >> 30);
		end
		sv = (x * t) >> 30;
		mag = (sv * 64'd29491 + (64'd1 << 29)) >> 30;
		return (quad >= 64'd2) ? -16'(mag) : 16'(mag);
	endfunction

	// Exponential entry e, exp(-e/64) in Q16.
	function automatic logic [16:0] exp_q16(input logic [E_W-1:0] e);
		longint unsigned acc;
		acc = 64'd1 << 32;
		for (int b = 0; b < E_W; b++) begin
			if (e[b]) begin
				acc = (acc * EXP_POW[b] + (64'd1 << 31)) >> 32;
			end
		end
		return 17'((acc + (64'd1 << 15)) >> 16);
	endfunction

endpackage

// ===== src/warped_cubic_point_morph_core.sv =====
// Top level of the warped cubic point morph core.
`timescale 1ns / 1ps
// Takes one curve point per cycle while the output is not stalled and returns its
// position on a cubic path from source to target, with the morph parameter warped per
// point by a sine of its phase. The pipeline has 17 register stages; throughput is one
// point per clock unless out_ready holds the output, and the depth is set by the chain of
// multipliers that forms the phase, the warp and the cubic weights. A stage that holds
// no point takes one from the stage before it even while the output waits, so bubbles
// close up. The sine and exponential tables are constant and read into a register each.
// Write configuration only while no point is in flight.
`include "assert_macros.svh"
module warped_cubic_point_morph_core #(
	parameter int MAX_POINTS = wcpm_pkg::MAX_POINTS_DEF,
	parameter int SINE_TABLE_DEPTH = wcpm_pkg::SINE_DEPTH_DEF,
	localparam int IDX_W = $clog2(MAX_POINTS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wcpm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wcpm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [IDX_W-1:0]                    phase_index,
	input  logic [11:0]                         from_x,
	input  logic [11:0]                         from_y,
	input  logic [11:0]                         to_x,
	input  logic [11:0]                         to_y,
	input  logic signed [12:0]                  slope_start_x,
	input  logic signed [12:0]                  slope_start_y,
	input  logic signed [12:0]                  slope_end_x,
	input  logic signed [12:0]                  slope_end_y,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [15:0]                  out_x,
	output logic signed [15:0]                  out_y
);

	localparam int N = wcpm_pkg::STAGES;
	localparam int SUM_W = ((IDX_W > 10) ? IDX_W : 10) + 1;
	localparam int K_W = $clog2(SINE_TABLE_DEPTH);
	localparam int KP_W = 24 + $clog2(SINE_TABLE_DEPTH + 1);
	localparam int E_W_L = wcpm_pkg::E_W;

	logic [16:0] gamma_q;
	logic [9:0]  shift_q;
	logic [24:0] step_q;

	logic [N:1] v_q;
	logic [N:1] rdy;

	wcpm_pkg::coord_t coord_in;
	wcpm_pkg::coord_t coord_q [1:14];
	logic signed [15:0] sin_q [4:8];

	logic signed [15:0] sin_rom [SINE_TABLE_DEPTH];
	logic [16:0]        exp_rom [wcpm_pkg::EXP_DEPTH];

	logic [SUM_W-1:0]      idx_sum;
	logic [SUM_W+24:0]     phase_prod;
	logic [23:0]           frac_s1;
	logic [KP_W-1:0]       kp;
	logic [K_W-1:0]        k_s2;
	logic signed [15:0]    s_s3;
	logic signed [32:0]    t_s4;
	logic signed [18:0]    d;
	logic [17:0]           dm_s5;
	logic [35:0]           sq_s6;
	logic [49:0]           ep;
	logic [E_W_L-1:0]      e_s7;
	logic                  big_s7;
	logic [16:0]           ex_s8;
	logic [16:0]           ex_s9;
	logic signed [34:0]    m_s9;
	logic signed [52:0]    p_s10;
	logic signed [63:0]    fs;
	logic signed [17:0]    f_sat;
	logic signed [17:0]    f_s11, f_s12;
	logic signed [18:0]    g_s11, g_s12;
	logic signed [37:0]    gg_s12, gf_s12, ff_s12;
	logic signed [56:0]    p0_s13, p1_s13, p2_s13, p3_s13;
	logic signed [wcpm_pkg::W_W-1:0] w0_s14, w1_s14, w2_s14, w3_s14;
	wcpm_pkg::blend_ctl_t  bctl;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q <= '0;
			shift_q <= '0;
			step_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wcpm_pkg::CFG_GAMMA: gamma_q <= cfg_data[16:0];
				wcpm_pkg::CFG_SHIFT: shift_q <= cfg_data[9:0];
				wcpm_pkg::CFG_STEP:  step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage takes a beat when it is empty or its own beat moves on.
	always_comb begin
		rdy[N] = !v_q[N] | out_ready;
		for (int k = N - 1; k >= 1; k--) begin
			rdy[k] = !v_q[k] | rdy[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[1]) begin
				v_q[1] <= in_valid;
			end
			for (int k = 2; k <= N; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k - 1];
				end
			end
		end
	end

	assign in_ready = rdy[1];
	assign out_valid = v_q[N];

	// Constant tables.
	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_sin
		localparam longint unsigned TURN = (64'(i) << 32) / 64'(SINE_TABLE_DEPTH);
		assign sin_rom[i] = wcpm_pkg::sine_q16(TURN);
	end
	for (genvar i = 0; i < wcpm_pkg::EXP_DEPTH; i++) begin : g_exp
		assign exp_rom[i] = wcpm_pkg::exp_q16(E_W_L'(i));
	end

	// Coordinate terms carried beside the warp.
	always_comb begin
		coord_in.ax = from_x;
		coord_in.bx = to_x;
		coord_in.c1x = $signed({4'b0, from_x}) + $signed({3'b0, from_x, 1'b0})
			+ 16'(slope_start_x);
		coord_in.c2x = $signed({4'b0, to_x}) + $signed({3'b0, to_x, 1'b0})
			- 16'(slope_end_x);
		coord_in.ay = from_y;
		coord_in.by = to_y;
		coord_in.c1y = $signed({4'b0, from_y}) + $signed({3'b0, from_y, 1'b0})
			+ 16'(slope_start_y);
		coord_in.c2y = $signed({4'b0, to_y}) + $signed({3'b0, to_y, 1'b0})
			- 16'(slope_end_y);
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			coord_q[1] <= coord_in;
		end
		for (int k = 2; k <= 14; k++) begin
			if (rdy[k]) begin
				coord_q[k] <= coord_q[k - 1];
			end
		end
	end

	// Stage 1: phase fraction.
	assign idx_sum = SUM_W'(phase_index) + SUM_W'(shift_q);
	assign phase_prod = (SUM_W + 25)'(idx_sum) * (SUM_W + 25)'(step_q);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			frac_s1 <= phase_prod[23:0];
		end
	end

	// Stage 2: sine table entry.
	assign kp = KP_W'(frac_s1) * KP_W'(SINE_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			k_s2 <= kp[24 +: K_W];
		end
	end

	// Stage 3: sine read.
	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			s_s3 <= sin_rom[k_s2];
		end
	end

	// Stage 4: sine times 0.7.
	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			t_s4 <= 33'(s_s3) * 33'sd45875;
			sin_q[4] <= s_s3;
		end
		for (int k = 5; k <= 8; k++) begin
			if (rdy[k]) begin
				sin_q[k] <= sin_q[k - 1];
			end
		end
	end

	// Stage 5: distance from the centre of the bump.
	assign d = $signed({2'b0, gamma_q}) - 19'sd32768
		+ 19'(wcpm_pkg::rshift_rnd(64'(t_s4), 16));

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			dm_s5 <= 18'(d[18] ? -d : d);
		end
	end

	// Stage 6: square.
	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			sq_s6 <= 36'(dm_s5) * 36'(dm_s5);
		end
	end

	// Stage 7: exponential table index.
	assign ep = 50'(sq_s6) * 50'd12800;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			e_s7 <= ep[32 +: E_W_L];
			big_s7 <= |ep[49:32 + E_W_L];
		end
	end

	// Stage 8: exponential read.
	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			ex_s8 <= big_s7 ? 17'd0 : exp_rom[e_s7];
		end
	end

	// Stage 9: sine times 1.67.
	always_ff @(posedge clk) begin
		if (rdy[9]) begin
			m_s9 <= 35'(sin_q[8]) * 35'sd109445;
			ex_s9 <= ex_s8;
		end
	end

	// Stage 10: warp offset.
	always_ff @(posedge clk) begin
		if (rdy[10]) begin
			p_s10 <= 53'(m_s9) * 53'($signed({1'b0, ex_s9}));
		end
	end

	// Stage 11: warped parameter, saturated to Q2.16.
	always_comb begin
		fs = $signed(64'(gamma_q)) + wcpm_pkg::rshift_rnd(64'(p_s10), 32);
		if (fs > 64'sd131071) begin
			f_sat = 18'sd131071;
		end else if (fs < -64'sd131072) begin
			f_sat = -18'sd131072;
		end else begin
			f_sat = 18'(fs);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[11]) begin
			f_s11 <= f_sat;
			g_s11 <= 19'sd65536 - 19'(f_sat);
		end
	end

	// Stage 12: squares and cross term.
	always_ff @(posedge clk) begin
		if (rdy[12]) begin
			gg_s12 <= 38'(g_s11) * 38'(g_s11);
			gf_s12 <= 38'(g_s11) * 38'(f_s11);
			ff_s12 <= 38'(f_s11) * 38'(f_s11);
			g_s12 <= g_s11;
			f_s12 <= f_s11;
		end
	end

	// Stage 13: cubes.
	always_ff @(posedge clk) begin
		if (rdy[13]) begin
			p0_s13 <= 57'(gg_s12) * 57'(g_s12);
			p1_s13 <= 57'(gg_s12) * 57'(f_s12);
			p2_s13 <= 57'(gf_s12) * 57'(f_s12);
			p3_s13 <= 57'(ff_s12) * 57'(f_s12);
		end
	end

	// Stage 14: Bernstein weights in Q16.
	always_ff @(posedge clk) begin
		if (rdy[14]) begin
			w0_s14 <= wcpm_pkg::W_W'(wcpm_pkg::rshift_rnd(64'(p0_s13), 32));
			w1_s14 <= wcpm_pkg::W_W'(wcpm_pkg::rshift_rnd(64'(p1_s13), 32));
			w2_s14 <= wcpm_pkg::W_W'(wcpm_pkg::rshift_rnd(64'(p2_s13), 32));
			w3_s14 <= wcpm_pkg::W_W'(wcpm_pkg::rshift_rnd(64'(p3_s13), 32));
		end
	end

	// Stages 15 to 17: blend per axis.
	assign bctl.ld_mul = rdy[15];
	assign bctl.ld_sum = rdy[16];
	assign bctl.ld_out = rdy[17];

	wcpm_blend u_blend_x (
		.clk (clk),
		.ctl (bctl),
		.w0  (w0_s14),
		.w1  (w1_s14),
		.w2  (w2_s14),
		.w3  (w3_s14),
		.a   (coord_q[14].ax),
		.b   (coord_q[14].bx),
		.c1  (coord_q[14].c1x),
		.c2  (coord_q[14].c2x),
		.res (out_x)
	);

	wcpm_blend u_blend_y (
		.clk (clk),
		.ctl (bctl),
		.w0  (w0_s14),
		.w1  (w1_s14),
		.w2  (w2_s14),
		.w3  (w3_s14),
		.a   (coord_q[14].ay),
		.b   (coord_q[14].by),
		.c1  (coord_q[14].c1y),
		.c2  (coord_q[14].c2y),
		.res (out_y)
	);

	`WCPM_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v_q[1], "accepted beat lost at entry")
	`WCPM_ASSERT_NOW(a_full_when_blocked, !in_ready, &v_q, "input blocked with a free stage")
	`WCPM_ASSERT_NEXT(a_warp_holds, v_q[9] && !rdy[9], v_q[9] && $stable(m_s9), "stalled stage changed")
	`WCPM_ASSERT_NOW(a_exp_bound, v_q[8], ex_s8 <= 17'd65536, "exponential above one")

endmodule

// ===== src/wcpm_blend.sv =====
// Cubic Bernstein blend of one axis: weighted products, sum, rounding and saturation.
`timescale 1ns / 1ps
module wcpm_blend (
	input  logic                              clk,
	input  wcpm_pkg::blend_ctl_t              ctl,
	input  logic signed [wcpm_pkg::W_W-1:0]   w0,
	input  logic signed [wcpm_pkg::W_W-1:0]   w1,
	input  logic signed [wcpm_pkg::W_W-1:0]   w2,
	input  logic signed [wcpm_pkg::W_W-1:0]   w3,
	input  logic [11:0]                       a,
	input  logic [11:0]                       b,
	input  logic signed [15:0]                c1,
	input  logic signed [15:0]                c2,
	output logic signed [15:0]                res
);

	logic signed [38:0] t0_s15, t1_s15, t2_s15, t3_s15;
	logic signed [40:0] sum_s16;
	logic signed [15:0] res_s17;
	logic signed [63:0] rnd;
	logic signed [15:0] sat;

	always_ff @(posedge clk) begin
		if (ctl.ld_mul) begin
			t0_s15 <= 39'(w0) * 39'($signed({1'b0, a}));
			t1_s15 <= 39'(w1) * 39'(c1);
			t2_s15 <= 39'(w2) * 39'(c2);
			t3_s15 <= 39'(w3) * 39'($signed({1'b0, b}));
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_sum) begin
			sum_s16 <= 41'(t0_s15) + 41'(t1_s15) + 41'(t2_s15) + 41'(t3_s15);
		end
	end

	always_comb begin
		rnd = wcpm_pkg::rshift_rnd(64'(sum_s16), 16);
		if (rnd > 64'sd32767) begin
			sat = 16'sd32767;
		end else if (rnd < -64'sd32768) begin
			sat = -16'sd32768;
		end else begin
			sat = 16'(rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_out) begin
			res_s17 <= sat;
		end
	end

	assign res = res_s17;

endmodule
